// ===== rtl/melody_sine_tone_player_core_defines.svh =====
// Assertion macros for the melody sine tone player checker.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef MELODY_SINE_TONE_PLAYER_CORE_DEFINES_SVH
`define MELODY_SINE_TONE_PLAYER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MSTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mstp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mstp assertion failed");

`endif

// ===== rtl/mstp_pkg.sv =====
// Shared constants, melody tables and struct types of the melody sine tone player.
// No dependencies; imported by the divider, the top level and the checker.
package mstp_pkg;

    localparam int SAMPLE_RATE     = 48000;
    localparam int MELODY_NOTES    = 23;
    localparam int SINE_TABLE_SIZE = 1024;   // power of two

    localparam int ROM_SLOTS  = 32;
    localparam int NOTE_W     = 5;
    localparam int NOTE_COUNT = (MELODY_NOTES % ROM_SLOTS == 0) ? ROM_SLOTS
                                                                : MELODY_NOTES % ROM_SLOTS;
    localparam int PHASE_W    = 16;
    localparam int DUR_W      = 16;
    localparam int AMP_W      = 11;
    localparam int LEVEL_W    = 12;

    localparam int SINE_ADDR_W = $clog2(SINE_TABLE_SIZE);
    localparam int QTR_ADDR_W  = SINE_ADDR_W - 1;
    localparam int QTR_ENTRIES = SINE_TABLE_SIZE / 4 + 1;
    localparam int SINE_MAG_W  = 15;
    localparam int SINE_U_W    = 16;          // 32768 +/- magnitude

    // long division of {phase, SINE_ADDR_W zeros} by the period
    localparam int DIV_STEPS = PHASE_W + SINE_ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // period in samples per melody frequency; 1 when freq*10 exceeds the rate
    localparam int PER_293 = (SAMPLE_RATE / 2930 == 0) ? 1 : SAMPLE_RATE / 2930;
    localparam int PER_329 = (SAMPLE_RATE / 3290 == 0) ? 1 : SAMPLE_RATE / 3290;
    localparam int PER_349 = (SAMPLE_RATE / 3490 == 0) ? 1 : SAMPLE_RATE / 3490;
    localparam int PER_391 = (SAMPLE_RATE / 3910 == 0) ? 1 : SAMPLE_RATE / 3910;
    localparam int PER_440 = (SAMPLE_RATE / 4400 == 0) ? 1 : SAMPLE_RATE / 4400;
    localparam int PER_523 = (SAMPLE_RATE / 5230 == 0) ? 1 : SAMPLE_RATE / 5230;
    localparam int PER_587 = (SAMPLE_RATE / 5870 == 0) ? 1 : SAMPLE_RATE / 5870;
    localparam int PER_659 = (SAMPLE_RATE / 6590 == 0) ? 1 : SAMPLE_RATE / 6590;
    localparam int PER_698 = (SAMPLE_RATE / 6980 == 0) ? 1 : SAMPLE_RATE / 6980;

    localparam logic [PHASE_W-1:0] MELODY_PERIOD [ROM_SLOTS] = '{
        16'(PER_293), 16'(PER_349), 16'(PER_587), 16'(PER_293), 16'(PER_349),
        16'(PER_587), 16'(PER_659), 16'(PER_698), 16'(PER_659), 16'(PER_698),
        16'(PER_659), 16'(PER_523), 16'(PER_440), 16'(PER_440), 16'(PER_293),
        16'(PER_293), 16'(PER_349), 16'(PER_440), 16'(PER_440), 16'(PER_293),
        16'(PER_349), 16'(PER_391), 16'(PER_329),
        16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1
    };

    localparam logic [DUR_W-1:0] MELODY_DURATION [ROM_SLOTS] = '{
        16'd500,  16'd500,  16'd2000, 16'd500,  16'd500,
        16'd2000, 16'd900,  16'd500,  16'd500,  16'd500,
        16'd500,  16'd500,  16'd2000, 16'd2000, 16'd2000,
        16'd2000, 16'd500,  16'd500,  16'd500,  16'd500,
        16'd500,  16'd500,  16'd500,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    // quarter-wave unsigned Q0.15 sine magnitudes, built at elaboration
    typedef logic [QTR_ENTRIES-1:0][SINE_MAG_W-1:0] t_qtr_rom;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_STEP_Q = PI_Q60 / SINE_TABLE_SIZE;
    localparam logic [63:0] PI_STEP_R = PI_Q60 % SINE_TABLE_SIZE;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic t_qtr_rom build_qtr_rom();
        t_qtr_rom    rom;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        int          n;
        for (int c = 0; c < QTR_ENTRIES; c++) begin
            b    = 64'(2 * c);
            x    = PI_STEP_Q * b + (PI_STEP_R * b) / SINE_TABLE_SIZE;
            x2   = mul_q60(x, x);
            term = x;
            sum  = x;
            for (n = 1; n < 30 && term != 64'd0; n++) begin
                term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            mag    = ((sum >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
            rom[c] = mag[SINE_MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam t_qtr_rom SINE_QTR_ROM = build_qtr_rom();

    // divider request and result
    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] dividend;
        logic [PHASE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [SINE_ADDR_W-1:0] index;      // floor(phase*size/N) mod size
        logic [PHASE_W-1:0]     phase_mod;  // phase mod N
    } t_div_rsp;

endpackage

// ===== rtl/mstp_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle over {phase, zeros} / period.
// Depends on mstp_pkg.
module mstp_divider
    import mstp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int NUM_W = DIV_STEPS;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_count;
    logic [PHASE_W:0]       r_rem;
    logic [NUM_W-1:0]       r_num;
    logic [PHASE_W-1:0]     r_div;
    logic [SINE_ADDR_W-1:0] r_quo;
    logic [PHASE_W-1:0]     r_mod;

    logic [PHASE_W:0] shifted;
    logic [PHASE_W:0] diff;
    logic             qbit;
    logic [PHASE_W:0] n_rem;

    always_comb begin
        shifted = {r_rem[PHASE_W-1:0], r_num[NUM_W-1]};
        diff    = shifted - {1'b0, r_div};
        qbit    = (shifted >= {1'b0, r_div});
        n_rem   = qbit ? diff : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {i_req.dividend, {SINE_ADDR_W{1'b0}}};
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_quo <= {r_quo[SINE_ADDR_W-2:0], qbit};
            // integer part done: remainder is phase mod N
            if (r_count == DIV_CNT_W'(PHASE_W - 1)) begin
                r_mod <= n_rem[PHASE_W-1:0];
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.index     = r_quo;
    assign o_rsp.phase_mod = r_mod;

endmodule

// ===== rtl/melody_sine_tone_player_core.sv =====
// Melody sine tone player: note sequencer, period divider, sine table and scaler.
// Depends on mstp_pkg and mstp_divider.
//
// Usage:
//   Input channel (i_valid / o_ready, payload i_sample_tick): one beat per audio
//   sample. A beat with i_sample_tick low is taken and ignored. A beat with the
//   tick high advances the melody (23 notes, wrapping) and yields one output beat.
//   Output channel (o_valid / i_ready): o_dac_level is amplitude*(1+sin), 0..4094,
//   and o_note_number the note played on that sample.
//   Config: i_cfg_we writes i_cfg_data into the amplitude register (reset 250);
//   write only while the block is idle.
// Timing:
//   A tick beat passes from accept to o_valid through the load state, the restoring
//   divider (one quotient bit per cycle), the table state and the multiply state.
//   o_ready is low during that time, so a new tick is taken only after the last
//   result has left the multiply state.
//   The output register holds a finished beat; the next tick is accepted while it
//   waits. If the receiver is still stalling when the next result is ready, the
//   sequencer waits in its last state until the register frees.
// Reset (synchronous, active low): note 0, duration and phase counters zero,
//   amplitude 250, output empty.
module melody_sine_tone_player_core
    import mstp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_sample_tick,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LEVEL_W-1:0] o_dac_level,
    output logic [NOTE_W-1:0]  o_note_number,
    input  logic               i_cfg_we,
    input  logic [AMP_W-1:0]   i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_TAB  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;

    localparam int HALF_SIZE = SINE_TABLE_SIZE / 2;
    localparam int QTR_SIZE  = SINE_TABLE_SIZE / 4;
    localparam int PROD_W    = AMP_W + SINE_U_W;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [AMP_W-1:0]       r_amplitude;
    logic [NOTE_W-1:0]      r_note_pointer;
    logic [DUR_W-1:0]       r_duration;
    logic [PHASE_W-1:0]     r_phase;
    logic [SINE_ADDR_W-1:0] r_index;
    logic [SINE_U_W-1:0]    r_sine_u;
    logic                   r_out_valid;
    logic [LEVEL_W-1:0]     r_dac_level;
    logic [NOTE_W-1:0]      r_note_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                   tick_accept;
    logic                   note_advance;
    logic [NOTE_W-1:0]      next_note;
    logic                   out_free;
    logic                   sine_neg;
    logic [SINE_ADDR_W:0]   half_fold;
    logic [SINE_ADDR_W-1:0] half_idx;
    logic [SINE_ADDR_W-1:0] qtr_fold;
    logic [QTR_ADDR_W-1:0]  qtr_idx;
    logic [SINE_MAG_W-1:0]  sine_mag;
    logic [SINE_U_W:0]      sine_u;
    logic [PROD_W-1:0]      level_prod;

    assign o_ready     = (r_state == S_IDLE);
    assign tick_accept = i_valid && o_ready && i_sample_tick;
    assign out_free    = !r_out_valid || i_ready;

    // note sequencer
    always_comb begin
        note_advance = (r_duration == MELODY_DURATION[r_note_pointer]);
        if (!note_advance) begin
            next_note = r_note_pointer;
        end else if (r_note_pointer == NOTE_W'(NOTE_COUNT - 1)) begin
            next_note = '0;
        end else begin
            next_note = r_note_pointer + 1'b1;
        end
    end

    assign div_req.start    = (r_state == S_LOAD);
    assign div_req.dividend = r_phase;
    assign div_req.divisor  = MELODY_PERIOD[r_note_pointer];

    mstp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // fold the table index onto the first quarter wave
    always_comb begin
        sine_neg  = (r_index > SINE_ADDR_W'(HALF_SIZE));
        half_fold = (SINE_ADDR_W + 1)'(SINE_TABLE_SIZE) - {1'b0, r_index};
        half_idx  = sine_neg ? half_fold[SINE_ADDR_W-1:0] : r_index;
        qtr_fold  = SINE_ADDR_W'(HALF_SIZE) - half_idx;
        qtr_idx   = (half_idx > SINE_ADDR_W'(QTR_SIZE)) ? qtr_fold[QTR_ADDR_W-1:0]
                                                         : half_idx[QTR_ADDR_W-1:0];
        sine_mag  = SINE_QTR_ROM[qtr_idx];
        sine_u    = sine_neg ? (17'd32768 - {2'b00, sine_mag})
                             : (17'd32768 + {2'b00, sine_mag});
    end

    assign level_prod = {{SINE_U_W{1'b0}}, r_amplitude} * {{AMP_W{1'b0}}, r_sine_u};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_TAB;
                end
            end
            S_TAB: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_amplitude    <= AMP_W'(250);
            r_note_pointer <= '0;
            r_duration     <= '0;
            r_phase        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_amplitude <= i_cfg_data;
            end
            if (tick_accept) begin
                r_note_pointer <= next_note;
                r_duration     <= (note_advance ? '0 : r_duration) + 1'b1;
            end
            if (r_state == S_DIV && div_rsp.done) begin
                r_phase <= div_rsp.phase_mod + 1'b1;
            end
            if (r_state == S_MUL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers; level is the product divided by 32768
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_rsp.done) begin
            r_index <= div_rsp.index;
        end
        if (r_state == S_TAB) begin
            r_sine_u <= sine_u[SINE_U_W-1:0];
        end
        if (r_state == S_MUL && out_free) begin
            r_dac_level <= level_prod[PROD_W-1:PROD_W-LEVEL_W];
            r_note_out  <= r_note_pointer;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_dac_level   = r_dac_level;
    assign o_note_number = r_note_out;

endmodule

// ===== rtl/mstp_checker.sv =====
// Port-level checker for the melody sine tone player, bound to the top level.
// Depends on mstp_pkg and melody_sine_tone_player_core_defines.svh.
`include "melody_sine_tone_player_core_defines.svh"

module mstp_checker
    import mstp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_sample_tick,
    input logic               o_valid,
    input logic               i_ready,
    input logic [LEVEL_W-1:0] o_dac_level,
    input logic [NOTE_W-1:0]  o_note_number,
    input logic               i_cfg_we,
    input logic [AMP_W-1:0]   i_cfg_data
);

    // stalled output beat holds
    `MSTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_dac_level) && $stable(o_note_number))

    // a tick beat makes the sequencer busy
    `MSTP_ASSERT_NEXT(a_busy_after_tick, i_clk, i_rst_n, i_valid && o_ready && i_sample_tick, !o_ready)

    // level never exceeds twice the largest amplitude
    `MSTP_ASSERT_IMPLY(a_level_range, i_clk, i_rst_n, o_valid, o_dac_level <= 12'd4094)

    // note number stays inside the melody
    `MSTP_ASSERT_IMPLY(a_note_range, i_clk, i_rst_n, o_valid, o_note_number < NOTE_W'(NOTE_COUNT))

endmodule

bind melody_sine_tone_player_core mstp_checker u_mstp_checker (.*);
